>>> sv/stk_pkg.sv
// stk_pkg: shared types, token and error codes, and character-class helpers
// for the source tokenizer; no dependencies
package stk_pkg;

    localparam int LINE_WIDTH_DEF   = 16;
    localparam int LENGTH_WIDTH_DEF = 12;
    localparam int KW_CHARS         = 6;
    localparam int KW_IDX_W         = $clog2(KW_CHARS);

    // token kinds
    localparam logic [5:0] K_IF     = 6'd4;
    localparam logic [5:0] K_INT    = 6'd0;
    localparam logic [5:0] K_REALKW = 6'd1;
    localparam logic [5:0] K_CHARKW = 6'd2;
    localparam logic [5:0] K_BOOLKW = 6'd3;
    localparam logic [5:0] K_ELSE   = 6'd5;
    localparam logic [5:0] K_BEGIN  = 6'd6;
    localparam logic [5:0] K_ENDKW  = 6'd7;
    localparam logic [5:0] K_WHILE  = 6'd8;
    localparam logic [5:0] K_RETURN = 6'd9;
    localparam logic [5:0] K_PLUS   = 6'd10;
    localparam logic [5:0] K_MINUS  = 6'd11;
    localparam logic [5:0] K_SLASH  = 6'd12;
    localparam logic [5:0] K_STAR   = 6'd13;
    localparam logic [5:0] K_CARET  = 6'd14;
    localparam logic [5:0] K_PCT    = 6'd15;
    localparam logic [5:0] K_AMP    = 6'd16;
    localparam logic [5:0] K_BAR    = 6'd17;
    localparam logic [5:0] K_BANG   = 6'd18;
    localparam logic [5:0] K_LBRK   = 6'd19;
    localparam logic [5:0] K_RBRK   = 6'd20;
    localparam logic [5:0] K_LPAR   = 6'd21;
    localparam logic [5:0] K_RPAR   = 6'd22;
    localparam logic [5:0] K_LT     = 6'd23;
    localparam logic [5:0] K_GT     = 6'd24;
    localparam logic [5:0] K_LE     = 6'd25;
    localparam logic [5:0] K_GE     = 6'd26;
    localparam logic [5:0] K_EQEQ   = 6'd27;
    localparam logic [5:0] K_NE     = 6'd28;
    localparam logic [5:0] K_ASSIGN = 6'd29;
    localparam logic [5:0] K_COLON  = 6'd30;
    localparam logic [5:0] K_SEMI   = 6'd31;
    localparam logic [5:0] K_COMMA  = 6'd32;
    localparam logic [5:0] K_IDENT  = 6'd33;
    localparam logic [5:0] K_INTLIT = 6'd34;
    localparam logic [5:0] K_REAL   = 6'd35;
    localparam logic [5:0] K_CHAR   = 6'd36;
    localparam logic [5:0] K_BOOL   = 6'd37;
    localparam logic [5:0] K_END    = 6'd38;
    localparam logic [5:0] K_ERROR  = 6'd39;

    // error codes
    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_COMMENT = 3'd1;
    localparam logic [2:0] E_DECIMAL = 3'd2;
    localparam logic [2:0] E_EQUALS  = 3'd3;
    localparam logic [2:0] E_CHARLIT = 3'd4;
    localparam logic [2:0] E_SYMBOL  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WORD, ST_NUMBER, ST_OPER, ST_QUOTE1, ST_QUOTE2, ST_ERROR
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic        in_comment;
        logic [7:0]  pend_op;
        logic [1:0]  dots;
        logic [7:0]  quoted;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{mode: ST_IDLE, in_comment: 1'b0, pend_op: 8'h00,
                                   dots: 2'd0, quoted: 8'h00};

    typedef struct packed {
        logic [5:0] kind;
        logic [2:0] err;
        logic [7:0] cv;
        logic       last;
    } t_tok;

    typedef logic [KW_CHARS-1:0][7:0] t_kw;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "/":     k = K_SLASH;
            ":":     k = K_COLON;
            "<":     k = K_LT;
            default: k = K_GT;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] double_op(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "/":     k = K_NE;
            "=":     k = K_EQEQ;
            ":":     k = K_ASSIGN;
            "<":     k = K_LE;
            default: k = K_GE;
        endcase
        return k;
    endfunction

    // word text is right-aligned in txt: first character is the highest used byte
    function automatic logic word_eq(input t_kw kw, input logic [2:0] len,
                                     input logic [8*KW_CHARS-1:0] txt, input int wlen);
        logic ok;
        int   idx;
        ok = (len == 3'(wlen));
        for (int j = 0; j < KW_CHARS; j++) begin
            idx = (j < wlen) ? (wlen - 1 - j) : 0;
            if (j < wlen && kw[j] != txt[8*idx +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [5:0] kw_kind(input t_kw kw, input logic [2:0] len);
        logic [5:0] k;
        k = K_IDENT;
        if      (word_eq(kw, len, "int", 3))    k = K_INT;
        else if (word_eq(kw, len, "real", 4))   k = K_REALKW;
        else if (word_eq(kw, len, "char", 4))   k = K_CHARKW;
        else if (word_eq(kw, len, "bool", 4))   k = K_BOOLKW;
        else if (word_eq(kw, len, "if", 2))     k = K_IF;
        else if (word_eq(kw, len, "else", 4))   k = K_ELSE;
        else if (word_eq(kw, len, "begin", 5))  k = K_BEGIN;
        else if (word_eq(kw, len, "end", 3))    k = K_ENDKW;
        else if (word_eq(kw, len, "while", 5))  k = K_WHILE;
        else if (word_eq(kw, len, "return", 6)) k = K_RETURN;
        else if (word_eq(kw, len, "true", 4))   k = K_BOOL;
        else if (word_eq(kw, len, "false", 5))  k = K_BOOL;
        return k;
    endfunction

endpackage

>>> sv/stk_if.sv
// stk_if: valid/ready channel interfaces for the tokenizer input bytes and
// output tokens; depends on stk_pkg for the default widths
interface stk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source(output valid, char_byte, end_of_input, input ready);
    modport sink(input valid, char_byte, end_of_input, output ready);
endinterface

interface stk_out_if #(
    parameter int LINE_W = stk_pkg::LINE_WIDTH_DEF,
    parameter int LEN_W  = stk_pkg::LENGTH_WIDTH_DEF
);
    logic              valid;
    logic              ready;
    logic [5:0]        token_kind;
    logic [2:0]        error_code;
    logic [LINE_W-1:0] line_no;
    logic [LEN_W-1:0]  lexeme_length;
    logic [7:0]        char_value;
    logic              last_of_run;

    modport source(output valid, token_kind, error_code, line_no, lexeme_length,
                   char_value, last_of_run, input ready);
    modport sink(input valid, token_kind, error_code, line_no, lexeme_length,
                 char_value, last_of_run, output ready);
endinterface

>>> sv/stk_step.sv
// stk_step: per-byte lexer next-state and token generation, pure logic
// depends on stk_pkg
module stk_step #(
    parameter int LINE_W = 16,
    parameter int LEN_W  = 12
) (
    input  stk_pkg::t_ctl                   i_ctl,
    input  stk_pkg::t_kw                    i_kw,
    input  logic [LEN_W-1:0]                i_len,
    input  logic [LINE_W-1:0]               i_line,
    input  logic [7:0]                      i_byte,
    input  logic                            i_eoi,
    output stk_pkg::t_ctl                   o_ctl,
    output logic                            o_kw_we,
    output logic [stk_pkg::KW_IDX_W-1:0]    o_kw_idx,
    output logic [LEN_W-1:0]                o_len,
    output logic [LINE_W-1:0]               o_line,
    output logic [LINE_W-1:0]               o_res_line,
    output logic                            o_push0,
    output logic                            o_push1,
    output stk_pkg::t_tok                   o_tok0,
    output stk_pkg::t_tok                   o_tok1,
    output logic [LEN_W-1:0]                o_len0,
    output logic [LEN_W-1:0]                o_len1
);
    import stk_pkg::*;

    // classification of the byte as the start of a new token
    logic             st_emit;
    logic [5:0]       st_kind;
    logic [2:0]       st_err;
    t_mode            st_mode;

    logic             av, bv;
    t_tok             atok, btok;
    logic [LEN_W-1:0] alen, blen;
    logic             do_start;
    logic [LINE_W-1:0] line_inc;
    logic [5:0]       w_kind;
    logic             w_short;
    logic [LEN_W-1:0] len_inc;

    always_comb begin
        st_emit = 1'b0;
        st_kind = K_ERROR;
        st_err  = E_NONE;
        st_mode = ST_IDLE;
        if (i_byte == " " || i_byte == 8'h0A || i_byte == 8'h09) begin
            st_mode = ST_IDLE;
        end else if (is_alpha(i_byte)) begin
            st_mode = ST_WORD;
        end else if (is_digit(i_byte)) begin
            st_mode = ST_NUMBER;
        end else if (i_byte < 8'h20 || i_byte > 8'h7E) begin
            st_mode = ST_IDLE;
        end else begin
            st_emit = 1'b1;
            case (i_byte)
                "+":  st_kind = K_PLUS;
                "-":  st_kind = K_MINUS;
                "*":  st_kind = K_STAR;
                "^":  st_kind = K_CARET;
                "%":  st_kind = K_PCT;
                "&":  st_kind = K_AMP;
                "|":  st_kind = K_BAR;
                "!":  st_kind = K_BANG;
                "[":  st_kind = K_LBRK;
                "]":  st_kind = K_RBRK;
                "(":  st_kind = K_LPAR;
                ")":  st_kind = K_RPAR;
                ";":  st_kind = K_SEMI;
                ",":  st_kind = K_COMMA;
                "/", "=", ":", "<", ">": begin
                    st_emit = 1'b0;
                    st_mode = ST_OPER;
                end
                8'h27: begin
                    st_emit = 1'b0;
                    st_mode = ST_QUOTE1;
                end
                default: begin
                    st_kind = K_ERROR;
                    st_err  = E_SYMBOL;
                    st_mode = ST_ERROR;
                end
            endcase
        end
    end

    assign line_inc = (i_byte == 8'h0A && !(&i_line)) ? i_line + LINE_W'(1) : i_line;
    assign len_inc  = (&i_len) ? i_len : i_len + LEN_W'(1);
    assign w_short  = (i_len <= LEN_W'(KW_CHARS));
    assign w_kind   = w_short ? kw_kind(i_kw, i_len[2:0]) : K_IDENT;

    always_comb begin
        o_ctl      = i_ctl;
        o_len      = i_len;
        o_line     = i_line;
        o_res_line = line_inc;
        o_kw_we    = 1'b0;
        o_kw_idx   = '0;
        av         = 1'b0;
        bv         = 1'b0;
        atok       = '0;
        btok       = '0;
        alen       = '0;
        blen       = '0;
        do_start   = 1'b0;

        if (i_eoi) begin
            o_res_line = i_line;
            if (i_ctl.mode != ST_ERROR) begin
                if (i_ctl.in_comment) begin
                    av = 1'b1;  atok.kind = K_ERROR;  atok.err = E_COMMENT;
                end else begin
                    case (i_ctl.mode)
                        ST_WORD: begin
                            av = 1'b1;  atok.kind = w_kind;  alen = i_len;
                        end
                        ST_NUMBER: begin
                            av = 1'b1;
                            if (i_ctl.dots >= 2'd2) begin
                                atok.kind = K_ERROR;  atok.err = E_DECIMAL;
                            end else begin
                                atok.kind = (i_ctl.dots != 2'd0) ? K_REAL : K_INTLIT;
                                alen = i_len;
                            end
                        end
                        ST_OPER: begin
                            av = 1'b1;
                            if (i_ctl.pend_op == "=") begin
                                atok.kind = K_ERROR;  atok.err = E_EQUALS;
                            end else begin
                                atok.kind = single_op(i_ctl.pend_op);
                                alen = LEN_W'(1);
                            end
                        end
                        ST_QUOTE1, ST_QUOTE2: begin
                            av = 1'b1;  atok.kind = K_ERROR;  atok.err = E_CHARLIT;
                        end
                        default: av = 1'b0;
                    endcase
                end
            end
            bv         = 1'b1;
            btok.kind  = K_END;
            o_ctl      = CTL_RESET;
            o_len      = '0;
            o_line     = LINE_W'(1);
        end else if (i_ctl.mode != ST_ERROR) begin
            o_line = line_inc;
            if (i_ctl.in_comment) begin
                if (i_byte == "#") o_ctl.in_comment = 1'b0;
            end else if (i_byte == "#") begin
                o_ctl.in_comment = 1'b1;
            end else begin
                case (i_ctl.mode)
                    ST_WORD: begin
                        if (is_alpha(i_byte) || is_digit(i_byte) || i_byte == "_") begin
                            o_kw_we  = (i_len < LEN_W'(KW_CHARS));
                            o_kw_idx = i_len[KW_IDX_W-1:0];
                            o_len    = len_inc;
                        end else begin
                            av = 1'b1;  atok.kind = w_kind;  alen = i_len;
                            do_start = 1'b1;
                        end
                    end
                    ST_NUMBER: begin
                        if (is_digit(i_byte) || i_byte == ".") begin
                            if (i_byte == "." && i_ctl.dots < 2'd2)
                                o_ctl.dots = i_ctl.dots + 2'd1;
                            o_len = len_inc;
                        end else if (i_ctl.dots >= 2'd2) begin
                            av = 1'b1;  atok.kind = K_ERROR;  atok.err = E_DECIMAL;
                            o_ctl.mode = ST_ERROR;
                        end else begin
                            av = 1'b1;
                            atok.kind = (i_ctl.dots != 2'd0) ? K_REAL : K_INTLIT;
                            alen = i_len;
                            do_start = 1'b1;
                        end
                    end
                    ST_OPER: begin
                        if (i_byte == "=") begin
                            av = 1'b1;  atok.kind = double_op(i_ctl.pend_op);
                            alen = LEN_W'(2);
                            o_ctl.mode = ST_IDLE;
                        end else if (i_ctl.pend_op == "=") begin
                            av = 1'b1;  atok.kind = K_ERROR;  atok.err = E_EQUALS;
                            o_ctl.mode = ST_ERROR;
                        end else begin
                            av = 1'b1;  atok.kind = single_op(i_ctl.pend_op);
                            alen = LEN_W'(1);
                            do_start = 1'b1;
                        end
                    end
                    ST_QUOTE1: begin
                        o_ctl.quoted = i_byte;
                        o_ctl.mode   = ST_QUOTE2;
                    end
                    ST_QUOTE2: begin
                        av = 1'b1;
                        if (i_byte == 8'h27) begin
                            atok.kind = K_CHAR;  atok.cv = i_ctl.quoted;
                            alen = LEN_W'(3);
                            o_ctl.mode = ST_IDLE;
                        end else begin
                            atok.kind = K_ERROR;  atok.err = E_CHARLIT;
                            o_ctl.mode = ST_ERROR;
                        end
                    end
                    default: do_start = 1'b1;
                endcase
            end

            if (do_start) begin
                o_ctl.mode = st_mode;
                bv         = st_emit;
                btok.kind  = st_kind;
                btok.err   = st_err;
                blen       = (st_emit && st_err == E_NONE) ? LEN_W'(1) : '0;
                if (st_mode == ST_WORD) begin
                    o_kw_we  = 1'b1;
                    o_kw_idx = '0;
                    o_len    = LEN_W'(1);
                end
                if (st_mode == ST_NUMBER) begin
                    o_len      = LEN_W'(1);
                    o_ctl.dots = 2'd0;
                end
                if (st_mode == ST_OPER) o_ctl.pend_op = i_byte;
            end
        end

        // pack results so that a single one always lands in slot 0
        o_push0 = av | bv;
        o_push1 = av & bv;
        o_tok0  = av ? atok : btok;
        o_len0  = av ? alen : blen;
        o_tok0.last = !(av & bv);
        o_tok1  = btok;
        o_len1  = blen;
        o_tok1.last = 1'b1;
    end

endmodule

>>> sv/stk_outq.sv
// stk_outq: four-entry result queue taking up to two tokens per cycle and
// delivering one on each pop; depends on stk_pkg
module stk_outq #(
    parameter int LINE_W = 16,
    parameter int LEN_W  = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push0,
    input  logic               i_push1,
    input  stk_pkg::t_tok      i_tok0,
    input  stk_pkg::t_tok      i_tok1,
    input  logic [LEN_W-1:0]   i_len0,
    input  logic [LEN_W-1:0]   i_len1,
    input  logic [LINE_W-1:0]  i_line,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_pop,
    output stk_pkg::t_tok      o_tok,
    output logic [LEN_W-1:0]   o_len,
    output logic [LINE_W-1:0]  o_line
);
    import stk_pkg::*;

    t_tok              r_tok  [4];
    logic [LEN_W-1:0]  r_len  [4];
    logic [LINE_W-1:0] r_line [4];
    logic [1:0]        r_wr, r_rd;
    logic [2:0]        r_cnt;
    logic [1:0]        n_wr, n_rd;
    logic [2:0]        n_cnt;
    logic              pop;

    assign pop     = i_pop && (r_cnt != 3'd0);
    assign o_space = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_tok   = r_tok[r_rd];
    assign o_len   = r_len[r_rd];
    assign o_line  = r_line[r_rd];

    always_comb begin
        n_wr  = r_wr + {1'b0, i_push0} + {1'b0, i_push1};
        n_rd  = r_rd + {1'b0, pop};
        n_cnt = r_cnt + {2'b0, i_push0} + {2'b0, i_push1} - {2'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_tok[r_wr]  <= i_tok0;
            r_len[r_wr]  <= i_len0;
            r_line[r_wr] <= i_line;
        end
        if (i_push1) begin
            r_tok[r_wr + 2'd1]  <= i_tok1;
            r_len[r_wr + 2'd1]  <= i_len1;
            r_line[r_wr + 2'd1] <= i_line;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    a_pair_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> i_push0)
        else $error("second result pushed without first");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push0 && !pop) |=> r_cnt != 3'd0)
        else $error("queue empty after push");

endmodule

>>> sv/source_tokenizer_core.sv
// source_tokenizer_core: byte-serial source lexer top level
// depends on stk_pkg, stk_if, stk_step, stk_outq
//
// usage:
//   i_tok carries one source byte per transaction, or an end-of-input mark
//   (end_of_input = 1, byte ignored). o_tok carries token transactions:
//   kind, error code, line number, lexeme length, quoted byte, and
//   last_of_run on the final token caused by one input transaction.
//   each input byte gives zero, one or two tokens; end of input gives the
//   flushed pending token (if any) followed by an end token, then the
//   lexer returns to its reset state for the next stream.
//   output: a token is registered into the result queue when the byte that
//   completes it is accepted, and is shown on o_tok once earlier tokens are taken.
//   throughput: one byte per cycle while o_tok.ready is high and each byte
//   yields at most one token; the four-entry result queue has a single read
//   port, so bytes yielding two tokens fill it until i_tok.ready drops.
//   reset: i_rst_n low (synchronous) empties the queue, clears the lexer
//   state and sets the line count to one.
//   stall: while o_tok.ready is low, tokens wait in the queue; i_tok.ready
//   drops once fewer than two queue slots are free.
module source_tokenizer_core #(
    parameter int LINE_WIDTH   = stk_pkg::LINE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = stk_pkg::LENGTH_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stk_in_if.sink       i_tok,
    stk_out_if.source    o_tok
);
    import stk_pkg::*;

    // lexer state
    t_ctl                   r_ctl;
    t_kw                    r_kw;
    logic [LENGTH_WIDTH-1:0] r_len;
    logic [LINE_WIDTH-1:0]   r_line;

    // next state from the byte logic
    t_ctl                    n_ctl;
    logic [LENGTH_WIDTH-1:0] n_len;
    logic [LINE_WIDTH-1:0]   n_line;
    logic                    kw_we;
    logic [KW_IDX_W-1:0]     kw_idx;

    // results of the current byte
    logic                    push0, push1;
    t_tok                    tok0, tok1, q_tok;
    logic [LENGTH_WIDTH-1:0] len0, len1, q_len;
    logic [LINE_WIDTH-1:0]   res_line, q_line;
    logic                    space, in_fire;

    assign i_tok.ready = space;
    assign in_fire     = i_tok.valid && space;

    stk_step #(.LINE_W(LINE_WIDTH), .LEN_W(LENGTH_WIDTH)) u_step (
        .i_ctl      (r_ctl),
        .i_kw       (r_kw),
        .i_len      (r_len),
        .i_line     (r_line),
        .i_byte     (i_tok.char_byte),
        .i_eoi      (i_tok.end_of_input),
        .o_ctl      (n_ctl),
        .o_kw_we    (kw_we),
        .o_kw_idx   (kw_idx),
        .o_len      (n_len),
        .o_line     (n_line),
        .o_res_line (res_line),
        .o_push0    (push0),
        .o_push1    (push1),
        .o_tok0     (tok0),
        .o_tok1     (tok1),
        .o_len0     (len0),
        .o_len1     (len1)
    );

    // result queue decouples the lexer from a stalled receiver
    stk_outq #(.LINE_W(LINE_WIDTH), .LEN_W(LENGTH_WIDTH)) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (in_fire && push0),
        .i_push1 (in_fire && push1),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .i_len0  (len0),
        .i_len1  (len1),
        .i_line  (res_line),
        .o_space (space),
        .o_valid (o_tok.valid),
        .i_pop   (o_tok.ready),
        .o_tok   (q_tok),
        .o_len   (q_len),
        .o_line  (q_line)
    );

    assign o_tok.token_kind    = q_tok.kind;
    assign o_tok.error_code    = q_tok.err;
    assign o_tok.char_value    = q_tok.cv;
    assign o_tok.last_of_run   = q_tok.last;
    assign o_tok.lexeme_length = q_len;
    assign o_tok.line_no       = q_line;

    // state register, advanced once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= CTL_RESET;
            r_len  <= '0;
            r_line <= LINE_WIDTH'(1);
        end else if (in_fire) begin
            r_ctl  <= n_ctl;
            r_len  <= n_len;
            r_line <= n_line;
        end
    end

    // keyword prefix bytes: only entries below the word length are compared
    always_ff @(posedge i_clk) begin
        if (in_fire && kw_we) r_kw[kw_idx] <= i_tok.char_byte;
    end

    // end of input always returns the lexer to its starting point
    a_eoi_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_tok.end_of_input) |=>
            (r_ctl.mode == ST_IDLE && !r_ctl.in_comment && r_line == LINE_WIDTH'(1)))
        else $error("lexer not restarted after end of input");

    // in error mode bytes are dropped, newlines included
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_tok.end_of_input && r_ctl.mode == ST_ERROR) |=>
            (r_ctl.mode == ST_ERROR && $stable(r_line)))
        else $error("error mode left before end of input");

    // comment bodies do not disturb the scan
    a_comment_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_tok.end_of_input && r_ctl.in_comment) |=>
            $stable(r_ctl.mode) && $stable(r_len))
        else $error("comment byte changed token state");

    // an error token moves the lexer into error mode
    a_error_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_tok.end_of_input && push0 && tok0.kind == K_ERROR) |=>
            r_ctl.mode == ST_ERROR)
        else $error("error token without error mode");

endmodule
